### rtl/pvm_pkg.sv
// ---------------------------------------------------------------------------
// pvm_pkg
// Shared constants, types and codes of the PCM voice mixer.
// ---------------------------------------------------------------------------
`default_nettype none

package pvm_pkg;

	// Sizing. SAMPLE_DEPTH must be a power of two.
	localparam int VOICE_COUNT  = 8;
	localparam int SAMPLE_DEPTH = 65536;

	localparam int SAMPLE_AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int VOICE_IW  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	// Width that holds start address + offset without loss
	localparam int SUM_W     = (SAMPLE_AW > 17) ? SAMPLE_AW : 17;

	localparam logic [16:0] LEN_MAX = 17'd65536;

	localparam logic signed [15:0] PCM_MAX = 16'sh7FFF;
	localparam logic signed [15:0] PCM_MIN = 16'sh8000;

	// Item kinds
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;
	localparam logic [1:0] KIND_TICK  = 2'd3;

	// One voice slot as stored in the voice memory
	typedef struct packed {
		logic [15:0] start_addr;
		logic [16:0] length;
		logic [16:0] offset;
		logic [31:0] start_time;
		logic        loop;
	} voice_t;

	localparam int VOICE_W = $bits(voice_t);

	// Sequencer to accumulator controls
	typedef struct packed {
		logic clear;
		logic add;
		logic finish;
	} acc_ctl_t;

endpackage

`default_nettype wire

### rtl/pvm_if.sv
// ---------------------------------------------------------------------------
// pvm_if
// Valid/ready channels: command items in, mixed output samples out.
// ---------------------------------------------------------------------------
`default_nettype none

interface pvm_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [31:0]        time_now;
	logic [2:0]         voice_slot;
	logic [15:0]        address;
	logic [16:0]        sample_length;
	logic [15:0]        start_delay;
	logic               loop_enable;
	logic signed [15:0] sample_value;

	modport source (
		output valid, kind, time_now, voice_slot, address, sample_length,
		       start_delay, loop_enable, sample_value,
		input  ready
	);
	modport sink (
		input  valid, kind, time_now, voice_slot, address, sample_length,
		       start_delay, loop_enable, sample_value,
		output ready
	);
endinterface

interface pvm_mix_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] mixed_sample;
	logic [3:0]         active_voices;
	logic               clipped;

	modport source (
		output valid, mixed_sample, active_voices, clipped,
		input  ready
	);
	modport sink (
		input  valid, mixed_sample, active_voices, clipped,
		output ready
	);
endinterface

`default_nettype wire

### rtl/pvm_ram.sv
// ---------------------------------------------------------------------------
// pvm_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module pvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/pvm_accum.sv
// ---------------------------------------------------------------------------
// pvm_accum
// Saturating mix accumulator, voice count, clip flag and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module pvm_accum (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pvm_pkg::acc_ctl_t  ctl,
	input  wire logic signed [15:0] sample,
	output logic                    can_finish,
	pvm_mix_if.source               mix
);

	logic signed [15:0] acc_q;
	logic [3:0]         cnt_q;
	logic               clip_q;
	logic signed [16:0] sum;
	logic signed [15:0] acc_nxt;
	logic               sat;

	logic               out_valid_q;
	logic signed [15:0] out_sample_q;
	logic [3:0]         out_cnt_q;
	logic               out_clip_q;

	// Overflow shows as disagreeing top two bits of the 17-bit sum
	always_comb begin
		sum = {acc_q[15], acc_q} + {sample[15], sample};
		sat = sum[16] != sum[15];
		if (!sat) begin
			acc_nxt = sum[15:0];
		end else if (sum[16]) begin
			acc_nxt = pvm_pkg::PCM_MIN;
		end else begin
			acc_nxt = pvm_pkg::PCM_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			cnt_q  <= '0;
			clip_q <= 1'b0;
		end else if (ctl.clear) begin
			acc_q  <= '0;
			cnt_q  <= '0;
			clip_q <= 1'b0;
		end else if (ctl.add) begin
			acc_q  <= acc_nxt;
			clip_q <= clip_q | sat;
			if (cnt_q != 4'hF) begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	assign can_finish = !out_valid_q || mix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (mix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			out_sample_q <= acc_q;
			out_cnt_q    <= cnt_q;
			out_clip_q   <= clip_q;
		end
	end

	assign mix.valid         = out_valid_q;
	assign mix.mixed_sample  = out_sample_q;
	assign mix.active_voices = out_cnt_q;
	assign mix.clipped       = out_clip_q;

	property p_finish_free;
		@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> can_finish;
	endproperty
	a_finish_free: assert property (p_finish_free)
		else $error("result overwritten while still pending");

endmodule

`default_nettype wire

### rtl/pcm_voice_mixer_top.sv
// ---------------------------------------------------------------------------
// pcm_voice_mixer_top
// Multi-voice PCM mixer over a loaded sample memory.
// ---------------------------------------------------------------------------
// Each cmd item loads a sample word, starts or stops a voice slot, or asks for
// one mixed output sample (tick). Load, start and stop complete in the cycle
// they are accepted, so such items can follow each other back to back. A tick
// walks the voice memory one slot per cycle: slot state is read, the due
// voice's sample address goes to the sample memory and the updated slot is
// written back, then the sample is added into a 16-bit saturating accumulator.
// A tick holds the cmd channel while it reads every voice slot and drains the
// reads of the two memories; it can take longer when the previous result has
// not been taken from mix. Results sit in an output register, so
// load/start/stop items are still accepted while a result waits. Sample memory
// has no reset; reading a word never written returns whatever the memory holds.
// ---------------------------------------------------------------------------
`default_nettype none

module pcm_voice_mixer_top (
	input  wire logic clk,
	input  wire logic arst_n,
	pvm_cmd_if.sink   cmd,
	pvm_mix_if.source mix
);

	localparam int VIW = pvm_pkg::VOICE_IW;
	localparam int SAW = pvm_pkg::SAMPLE_AW;

	localparam logic [7:0]     VC_L     = 8'(pvm_pkg::VOICE_COUNT);
	localparam logic [VIW-1:0] LAST_IDX = VIW'(pvm_pkg::VOICE_COUNT - 1);

	// Sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]     state_q;
	logic [VIW-1:0] rd_idx_q;
	logic [31:0]    now_q;
	logic [pvm_pkg::VOICE_COUNT-1:0] valid_q;

	// s1: voice entry back from memory; s2: sample back from memory
	logic           s1_q;
	logic [VIW-1:0] vidx_s1;
	logic           s2_q;
	logic           play_s2;

	logic accept;
	logic slot_ok;
	logic [VIW-1:0] slot_idx;

	// Voice memory ports
	logic                         vram_we;
	logic [VIW-1:0]               vram_waddr;
	pvm_pkg::voice_t              vram_wdata;
	logic [pvm_pkg::VOICE_W-1:0]  vram_rdata;
	pvm_pkg::voice_t              vrd;
	pvm_pkg::voice_t              new_voice;
	pvm_pkg::voice_t              upd_voice;

	// Sample memory ports
	logic                         sram_we;
	logic [SAW-1:0]               sram_waddr;
	logic [SAW-1:0]               sram_raddr;
	logic [15:0]                  sram_rdata;
	logic [pvm_pkg::SUM_W-1:0]    load_ext;
	logic [pvm_pkg::SUM_W-1:0]    play_sum;

	// Per-slot decisions in s1
	logic        due;
	logic        play;
	logic [16:0] noff;
	logic        at_end;

	pvm_pkg::acc_ctl_t acc_ctl;
	logic              can_finish;

	assign cmd.ready = state_q == ST_IDLE;
	assign accept    = cmd.valid && cmd.ready;
	assign slot_ok   = {5'd0, cmd.voice_slot} < VC_L;
	assign slot_idx  = VIW'(cmd.voice_slot);

	// New voice entry from a start item
	always_comb begin
		new_voice.start_addr = cmd.address;
		new_voice.length     = (cmd.sample_length > pvm_pkg::LEN_MAX) ?
		                       pvm_pkg::LEN_MAX : cmd.sample_length;
		new_voice.offset     = '0;
		new_voice.start_time = cmd.time_now + {16'd0, cmd.start_delay};
		new_voice.loop       = cmd.loop_enable;
	end

	// Slot evaluation against the entry read back in s1
	assign vrd    = pvm_pkg::voice_t'(vram_rdata);
	assign due    = valid_q[vidx_s1] && (now_q >= vrd.start_time);
	assign play   = due && (vrd.offset < vrd.length);
	assign noff   = vrd.offset + {16'd0, play};
	assign at_end = due && (noff >= vrd.length);

	always_comb begin
		upd_voice        = vrd;
		upd_voice.offset = (at_end && vrd.loop) ? 17'd0 : noff;
	end

	// Address wraps modulo the (power of two) sample depth
	assign play_sum   = pvm_pkg::SUM_W'(vrd.start_addr) + pvm_pkg::SUM_W'(vrd.offset);
	assign sram_raddr = play_sum[SAW-1:0];
	assign load_ext   = pvm_pkg::SUM_W'(cmd.address);
	assign sram_waddr = load_ext[SAW-1:0];
	assign sram_we    = accept && (cmd.kind == pvm_pkg::KIND_LOAD);

	// Start items write while idle; write-back only happens during a tick
	always_comb begin
		if (state_q == ST_IDLE) begin
			vram_we    = accept && (cmd.kind == pvm_pkg::KIND_START) && slot_ok;
			vram_waddr = slot_idx;
			vram_wdata = new_voice;
		end else begin
			vram_we    = s1_q && due;
			vram_waddr = vidx_s1;
			vram_wdata = upd_voice;
		end
	end

	pvm_ram #(
		.WIDTH (pvm_pkg::VOICE_W),
		.DEPTH (pvm_pkg::VOICE_COUNT)
	) u_voice_ram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (vram_waddr),
		.wdata (vram_wdata),
		.raddr (rd_idx_q),
		.rdata (vram_rdata)
	);

	pvm_ram #(
		.WIDTH (16),
		.DEPTH (pvm_pkg::SAMPLE_DEPTH)
	) u_sample_ram (
		.clk   (clk),
		.we    (sram_we),
		.waddr (sram_waddr),
		.wdata (cmd.sample_value),
		.raddr (sram_raddr),
		.rdata (sram_rdata)
	);

	// Slot valid bits: set by start, cleared by stop or at the end of a
	// non-looping voice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (accept && slot_ok && (cmd.kind == pvm_pkg::KIND_START)) begin
				valid_q[slot_idx] <= 1'b1;
			end
			if (accept && slot_ok && (cmd.kind == pvm_pkg::KIND_STOP)) begin
				valid_q[slot_idx] <= 1'b0;
			end
			if (s1_q && at_end && !vrd.loop) begin
				valid_q[vidx_s1] <= 1'b0;
			end
		end
	end

	// Tick sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			s1_q     <= 1'b0;
			s2_q     <= 1'b0;
			play_s2  <= 1'b0;
		end else begin
			s1_q    <= state_q == ST_SCAN;
			s2_q    <= s1_q;
			play_s2 <= s1_q && play;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (cmd.kind == pvm_pkg::KIND_TICK)) begin
						state_q  <= ST_SCAN;
						rd_idx_q <= '0;
					end
				end
				ST_SCAN: begin
					rd_idx_q <= rd_idx_q + VIW'(1);
					if (rd_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!s1_q && !s2_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (can_finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd.kind == pvm_pkg::KIND_TICK)) begin
			now_q <= cmd.time_now;
		end
		vidx_s1 <= rd_idx_q;
	end

	assign acc_ctl.clear  = accept && (cmd.kind == pvm_pkg::KIND_TICK);
	assign acc_ctl.add    = s2_q && play_s2;
	assign acc_ctl.finish = (state_q == ST_FIN) && can_finish;

	pvm_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (acc_ctl),
		.sample     (sram_rdata),
		.can_finish (can_finish),
		.mix        (mix)
	);

	// Write-back never hits the slot being read in the same cycle
	property p_no_wb_collision;
		@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && vram_we) |-> (vram_waddr != rd_idx_q);
	endproperty
	a_no_wb_collision: assert property (p_no_wb_collision)
		else $error("voice write-back collides with read");

	// Pipeline is empty by the time the result is taken
	property p_fin_drained;
		@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (!s1_q && !s2_q);
	endproperty
	a_fin_drained: assert property (p_fin_drained)
		else $error("result taken before pipeline drained");

	// A sample add always follows a slot evaluation in the cycle before
	property p_add_follows_s1;
		@(posedge clk) disable iff (!arst_n)
		acc_ctl.add |-> $past(s1_q);
	endproperty
	a_add_follows_s1: assert property (p_add_follows_s1)
		else $error("accumulate without slot evaluation");

	// The accumulate stage of the tick pipeline stays empty while idle
	property p_idle_quiet;
		@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !s2_q;
	endproperty
	a_idle_quiet: assert property (p_idle_quiet)
		else $error("tick pipeline active while idle");

endmodule

`default_nettype wire
